>>> design/dabs_pkg.sv
// Shared types and constants for the daily alarm beep sequencer.
// Holds the item structs, the phase encoding and the register map.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package dabs_pkg;

  // Default width of the millisecond time base.
  localparam int MS_WIDTH_DEF = 32;

  // Epoch seconds must exceed this before the wall clock is trusted.
  localparam logic [31:0] EPOCH_VALID_THRESHOLD = 32'd1700000000;

  // Day marker that no 9-bit day of year can match.
  localparam logic [9:0] NEVER_FIRED_DAY = 10'h3FF;

  // Configuration register reset values.
  localparam logic [4:0]  ALARM_HOUR_RST  = 5'd7;
  localparam logic [5:0]  ALARM_MINUTE_RST = 6'd0;
  localparam logic [31:0] TOTAL_DUR_RST   = 32'd60000;
  localparam logic [31:0] TONE_ON_RST     = 32'd500;
  localparam logic [31:0] TONE_OFF_RST    = 32'd500;

  // Configuration byte addresses, one 32-bit register every four bytes.
  localparam int CFG_ADDR_W = 5;
  localparam logic [CFG_ADDR_W-1:0] ADDR_ALARM_HOUR   = 5'h00;
  localparam logic [CFG_ADDR_W-1:0] ADDR_ALARM_MINUTE = 5'h04;
  localparam logic [CFG_ADDR_W-1:0] ADDR_TOTAL_DUR    = 5'h08;
  localparam logic [CFG_ADDR_W-1:0] ADDR_TONE_ON      = 5'h0C;
  localparam logic [CFG_ADDR_W-1:0] ADDR_TONE_OFF     = 5'h10;

  // Sequencer phase, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ON   = 3'b010,
    PH_OFF  = 3'b100
  } phase_t;

  // One input item: the wall-clock tick.
  typedef struct packed {
    logic [4:0]  wall_hour;
    logic [5:0]  wall_minute;
    logic [8:0]  day_of_year;
    logic [31:0] epoch_seconds;
    logic [31:0] now_ms;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic tone_enable;
    logic alarm_active;
    logic alarm_started;
    logic alarm_completed;
  } out_item_t;

endpackage

`default_nettype wire

>>> design/daily_alarm_beep_sequencer_top.sv
// An accepted item passes the tick register, then shows its result on out_valid from the
// result register. Throughput: one item per cycle unless out_ready stalls; the tick
// register feeds the phase logic, whose outcome and state update are captured together.
// Reset: synchronous, active low; clears valids, returns to idle with the day marker
// set to never fired and all configuration registers at their documented defaults.
// Depends on dabs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module daily_alarm_beep_sequencer_top
  import dabs_pkg::*;
#(
  parameter int MS_WIDTH = MS_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Tick input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  // Configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // Width used to compare elapsed time against 32-bit durations.
  localparam int CW = (MS_WIDTH > 32) ? MS_WIDTH : 32;

  // Configuration registers.
  logic [4:0]  alarm_hour_r;
  logic [5:0]  alarm_minute_r;
  logic [31:0] total_dur_r;
  logic [31:0] tone_on_r;
  logic [31:0] tone_off_r;
  logic        cfg_wr;

  // Sequencer state.
  phase_t              phase_r, phase_nxt;
  logic [MS_WIDTH-1:0] alarm_start_r, alarm_start_nxt;
  logic [MS_WIDTH-1:0] phase_start_r, phase_start_nxt;
  logic [9:0]          last_day_r, last_day_nxt;

  // Pipeline registers.
  logic      tick_valid_r;
  in_item_t  tick_r;
  logic      out_valid_r;
  out_item_t out_r, out_nxt;
  logic      advance;

  // Datapath signals.
  logic [MS_WIDTH-1:0] now_w;
  logic [MS_WIDTH-1:0] el_alarm;
  logic [MS_WIDTH-1:0] el_phase;
  logic                time_match;
  logic                dur_done;
  logic                on_done;
  logic                off_done;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_hour_r   <= ALARM_HOUR_RST;
      alarm_minute_r <= ALARM_MINUTE_RST;
      total_dur_r    <= TOTAL_DUR_RST;
      tone_on_r      <= TONE_ON_RST;
      tone_off_r     <= TONE_OFF_RST;
    end else if (cfg_wr) begin
      unique case (paddr)
        ADDR_ALARM_HOUR:   alarm_hour_r   <= pwdata[4:0];
        ADDR_ALARM_MINUTE: alarm_minute_r <= pwdata[5:0];
        ADDR_TOTAL_DUR:    total_dur_r    <= pwdata;
        ADDR_TONE_ON:      tone_on_r      <= pwdata;
        ADDR_TONE_OFF:     tone_off_r     <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (paddr)
      ADDR_ALARM_HOUR:   prdata = {27'd0, alarm_hour_r};
      ADDR_ALARM_MINUTE: prdata = {26'd0, alarm_minute_r};
      ADDR_TOTAL_DUR:    prdata = total_dur_r;
      ADDR_TONE_ON:      prdata = tone_on_r;
      ADDR_TONE_OFF:     prdata = tone_off_r;
      default:           prdata = 32'd0;
    endcase
  end

  // Handshake: the tick register moves on whenever the result slot is free or draining.
  assign advance   = tick_valid_r & (~out_valid_r | out_ready);
  assign in_ready  = ~tick_valid_r | advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Tick register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r <= 1'b0;
    end else if (in_ready) begin
      tick_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tick_r <= in_data;
    end
  end

  // Elapsed times on the wrapping millisecond base and their threshold checks.
  assign now_w    = MS_WIDTH'(tick_r.now_ms);
  assign el_alarm = now_w - alarm_start_r;
  assign el_phase = now_w - phase_start_r;
  assign dur_done = CW'(el_alarm) >= CW'(total_dur_r);
  assign on_done  = CW'(el_phase) >= CW'(tone_on_r);
  assign off_done = CW'(el_phase) >= CW'(tone_off_r);

  assign time_match = (tick_r.epoch_seconds > EPOCH_VALID_THRESHOLD) &&
                      (tick_r.wall_hour == alarm_hour_r) &&
                      (tick_r.wall_minute == alarm_minute_r) &&
                      ({1'b0, tick_r.day_of_year} != last_day_r);

  // Phase sequencing; the total-duration stop wins over any toggle.
  always_comb begin
    phase_nxt       = phase_r;
    alarm_start_nxt = alarm_start_r;
    phase_start_nxt = phase_start_r;
    last_day_nxt    = last_day_r;
    out_nxt         = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (time_match) begin
          phase_nxt             = PH_ON;
          alarm_start_nxt       = now_w;
          phase_start_nxt       = now_w;
          last_day_nxt          = {1'b0, tick_r.day_of_year};
          out_nxt.alarm_started = 1'b1;
        end
      end
      PH_ON: begin
        if (dur_done) begin
          phase_nxt               = PH_IDLE;
          out_nxt.alarm_completed = 1'b1;
        end else if (on_done) begin
          phase_nxt       = PH_OFF;
          phase_start_nxt = now_w;
        end
      end
      PH_OFF: begin
        if (dur_done) begin
          phase_nxt               = PH_IDLE;
          out_nxt.alarm_completed = 1'b1;
        end else if (off_done) begin
          phase_nxt       = PH_ON;
          phase_start_nxt = now_w;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    out_nxt.tone_enable  = (phase_nxt == PH_ON);
    out_nxt.alarm_active = (phase_nxt != PH_IDLE);
  end

  // State commit as the tick's result is captured.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      alarm_start_r <= '0;
      phase_start_r <= '0;
      last_day_r    <= NEVER_FIRED_DAY;
    end else if (advance) begin
      phase_r       <= phase_nxt;
      alarm_start_r <= alarm_start_nxt;
      phase_start_r <= phase_start_nxt;
      last_day_r    <= last_day_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/dabs_checker.sv
// Port-level checks for the daily alarm beep sequencer, with the bind to its top level.
// Depends on dabs_pkg and daily_alarm_beep_sequencer_top.
`timescale 1ns / 1ps
`default_nettype none

module dabs_checker
  import dabs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // A stalled result item holds until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed or dropped while stalled");

  // The tone only sounds while the alarm is active.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.tone_enable || out_data.alarm_active)
    else $error("tone enabled outside an active alarm");

  // A start item always leaves the alarm active with the tone on.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.alarm_started |->
      out_data.alarm_active && out_data.tone_enable && !out_data.alarm_completed)
    else $error("start item without active tone");

  // A completion item leaves the alarm idle and silent.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.alarm_completed |->
      !out_data.alarm_active && !out_data.tone_enable)
    else $error("completion item while still active");

endmodule

bind daily_alarm_beep_sequencer_top dabs_checker u_dabs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
